// ===== rtl/core/cbq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cascaded biquad filter.
// No dependencies; every other file in this folder imports it.
package cbq_pkg;

  localparam int COEF_FRAC_BITS = 16;
  localparam int HIST_FRAC_BITS = 8;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
  localparam int HIST_BITS      = HIST_FRAC_BITS + 18;
  localparam int FF_BITS        = 3 * COEF_BITS;
  localparam int FB_BITS        = 2 * COEF_BITS;
  localparam int PROD_BITS      = COEF_BITS + HIST_BITS;
  localparam int ACC_BITS       = PROD_BITS + 3;
  localparam int SAMPLE_BITS    = 16;
  localparam int INT_BITS       = HIST_BITS - HIST_FRAC_BITS;
  localparam int OUTV_BITS      = INT_BITS + 1;

  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_ADDR_BITS  = 5;
  localparam int CFG_IDX_LSB    = 3;

  localparam logic [SAMPLE_BITS-1:0] MIDSCALE = 16'h7FFF;

  // register indexes
  localparam logic [1:0] REG_SEC1_FF = 2'd0;
  localparam logic [1:0] REG_SEC1_FB = 2'd1;
  localparam logic [1:0] REG_SEC2_FF = 2'd2;
  localparam logic [1:0] REG_SEC2_FB = 2'd3;

  localparam logic [FF_BITS-1:0] FF_RESET = FF_BITS'(1) << COEF_FRAC_BITS;

  // tap sequence of one section
  localparam int STEP_BITS = 3;
  localparam logic [STEP_BITS-1:0] TAP_B0 = 3'd0;
  localparam logic [STEP_BITS-1:0] TAP_B1 = 3'd1;
  localparam logic [STEP_BITS-1:0] TAP_B2 = 3'd2;
  localparam logic [STEP_BITS-1:0] TAP_A1 = 3'd3;
  localparam logic [STEP_BITS-1:0] TAP_A2 = 3'd4;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [HIST_BITS-1:0] hist_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic sub;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC_LAST,
    ST_ROUND,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/cbq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels for the sample input and the filtered output.
// Depends on cbq_pkg for field widths.
interface cbq_in_if
  import cbq_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface cbq_out_if
  import cbq_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] dac_sample;
  logic                   clipped;

  modport source (output valid, output dac_sample, output clipped, input ready);
  modport sink (input valid, input dac_sample, input clipped, output ready);
endinterface

// ===== rtl/core/cbq_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: registered product, then add or subtract.
// Depends on cbq_pkg.
module cbq_mac
  import cbq_pkg::*;
(
  input  logic     clk,
  input  coef_t    coef,
  input  hist_t    data,
  input  mac_ctl_t ctl,
  output acc_t     acc
);

  prod_t prod_r;
  logic  sub_r;
  acc_t  acc_r;
  acc_t  prod_ext;

  assign prod_ext = {{(ACC_BITS-PROD_BITS){prod_r[PROD_BITS-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= coef * data;
      sub_r  <= ctl.sub;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/core/cascaded_biquad_iir_filter.sv =====
`timescale 1ns / 1ps
// Top level of the two-section direct-form-I biquad filter with APB setup.
// Depends on cbq_pkg, cbq_if (channel interfaces) and cbq_mac.

// One sample enters, has the 0x7FFF midscale removed, runs through section
// one and then section two, and leaves with the offset restored, saturated
// to 16 bits with a clip flag. A single 18x26 multiplier with a registered
// product and accumulator does all ten products, one per cycle: each section
// runs its five taps, then a drain state and a round/saturate state. The
// result waits in ST_OUT until the output register is free; the input is
// ready again in the cycle after it is loaded. The input is ready only while
// the unit is idle; a result waiting in the output register does not keep the
// next sample from being accepted, only its result from leaving ST_OUT. Each
// register of the coefficient bank sits at byte address 8*i on the APB port.
module cascaded_biquad_iir_filter
  import cbq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  cbq_in_if.sink                   in_if,
  cbq_out_if.source                out_if,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  // coefficient bank
  logic [FF_BITS-1:0] sec1_ff_r, sec2_ff_r;
  logic [FB_BITS-1:0] sec1_fb_r, sec2_fb_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_IDX_LSB+1:CFG_IDX_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec1_ff_r <= FF_RESET;
      sec1_fb_r <= '0;
      sec2_ff_r <= FF_RESET;
      sec2_fb_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SEC1_FF: sec1_ff_r <= pwdata[FF_BITS-1:0];
        REG_SEC1_FB: sec1_fb_r <= pwdata[FB_BITS-1:0];
        REG_SEC2_FF: sec2_ff_r <= pwdata[FF_BITS-1:0];
        REG_SEC2_FB: sec2_fb_r <= pwdata[FB_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SEC1_FF: prdata = CFG_DATA_BITS'(sec1_ff_r);
      REG_SEC1_FB: prdata = CFG_DATA_BITS'(sec1_fb_r);
      REG_SEC2_FF: prdata = CFG_DATA_BITS'(sec2_ff_r);
      REG_SEC2_FB: prdata = CFG_DATA_BITS'(sec2_fb_r);
      default:     prdata = '0;
    endcase
  end

  // sequencer
  state_t               state_r, state_nxt;
  logic                 sec_r;
  logic [STEP_BITS-1:0] step_r;
  hist_t                x_r;
  mac_ctl_t             mac_ctl;
  logic                 in_beat;
  logic                 out_load;
  logic                 round_en;

  hist_t s1_in_d1_r, s1_in_d2_r, s1_out_d1_r, s1_out_d2_r;
  hist_t s2_in_d1_r, s2_in_d2_r, s2_out_d1_r, s2_out_d2_r;

  logic                 out_valid_r;
  logic [SAMPLE_BITS-1:0] dac_r;
  logic                 clip_r;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_beat     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mac_ctl   = '0;
    out_load  = 1'b0;
    round_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          mac_ctl.clear = 1'b1;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_en = (step_r != TAP_B0);
        mac_ctl.sub    = (step_r == TAP_A1) || (step_r == TAP_A2);
        if (step_r == TAP_A2) begin
          state_nxt = ST_ACC_LAST;
        end
      end
      ST_ACC_LAST: begin
        mac_ctl.acc_en = 1'b1;
        state_nxt      = ST_ROUND;
      end
      ST_ROUND: begin
        round_en = 1'b1;
        if (!sec_r) begin
          mac_ctl.clear = 1'b1;
          state_nxt     = ST_MUL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= 1'b0;
      step_r <= TAP_B0;
    end else if (in_beat) begin
      sec_r  <= 1'b0;
      step_r <= TAP_B0;
    end else if (state_r == ST_MUL) begin
      step_r <= (step_r == TAP_A2) ? TAP_B0 : step_r + STEP_BITS'(1);
    end else if (round_en) begin
      sec_r <= 1'b1;
    end
  end

  // operand select
  logic [FF_BITS-1:0] ff_sel;
  logic [FB_BITS-1:0] fb_sel;
  hist_t              in_d1, in_d2, out_d1, out_d2;
  coef_t              mac_coef;
  hist_t              mac_data;
  acc_t               acc;

  assign ff_sel = sec_r ? sec2_ff_r : sec1_ff_r;
  assign fb_sel = sec_r ? sec2_fb_r : sec1_fb_r;
  assign in_d1  = sec_r ? s2_in_d1_r  : s1_in_d1_r;
  assign in_d2  = sec_r ? s2_in_d2_r  : s1_in_d2_r;
  assign out_d1 = sec_r ? s2_out_d1_r : s1_out_d1_r;
  assign out_d2 = sec_r ? s2_out_d2_r : s1_out_d2_r;

  always_comb begin
    unique case (step_r)
      TAP_B0: begin
        mac_coef = ff_sel[COEF_BITS-1:0];
        mac_data = x_r;
      end
      TAP_B1: begin
        mac_coef = ff_sel[2*COEF_BITS-1:COEF_BITS];
        mac_data = in_d1;
      end
      TAP_B2: begin
        mac_coef = ff_sel[3*COEF_BITS-1:2*COEF_BITS];
        mac_data = in_d2;
      end
      TAP_A1: begin
        mac_coef = fb_sel[COEF_BITS-1:0];
        mac_data = out_d1;
      end
      TAP_A2: begin
        mac_coef = fb_sel[2*COEF_BITS-1:COEF_BITS];
        mac_data = out_d2;
      end
      default: begin
        mac_coef = '0;
        mac_data = '0;
      end
    endcase
  end

  cbq_mac u_mac (
    .clk  (clk),
    .coef (mac_coef),
    .data (mac_data),
    .ctl  (mac_ctl),
    .acc  (acc)
  );

  // round half up, floor, saturate to history range
  acc_t                       acc_rnd;
  acc_t                       acc_shr;
  logic [ACC_BITS-HIST_BITS:0] acc_top;
  logic                       acc_fits;
  hist_t                      sec_y;

  assign acc_rnd  = acc + (ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1));
  assign acc_shr  = acc_rnd >>> COEF_FRAC_BITS;
  assign acc_top  = acc_shr[ACC_BITS-1:HIST_BITS-1];
  assign acc_fits = (&acc_top) || !(|acc_top);
  assign sec_y    = acc_fits ? acc_shr[HIST_BITS-1:0]
                  : (acc_shr[ACC_BITS-1] ? {1'b1, {(HIST_BITS-1){1'b0}}}
                                         : {1'b0, {(HIST_BITS-1){1'b1}}});

  // sample offset removal
  logic signed [SAMPLE_BITS:0] samp_off;
  hist_t                       x_in;

  assign samp_off = $signed({1'b0, in_if.adc_sample}) - $signed({1'b0, MIDSCALE});
  assign x_in     = {{(HIST_BITS-SAMPLE_BITS-1){samp_off[SAMPLE_BITS]}}, samp_off}
                    <<< HIST_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      x_r <= x_in;
    end else if (round_en) begin
      x_r <= sec_y;
    end
  end

  // history: shift on each section's round cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_in_d1_r  <= '0;
      s1_in_d2_r  <= '0;
      s1_out_d1_r <= '0;
      s1_out_d2_r <= '0;
      s2_in_d1_r  <= '0;
      s2_in_d2_r  <= '0;
      s2_out_d1_r <= '0;
      s2_out_d2_r <= '0;
    end else if (round_en) begin
      if (!sec_r) begin
        s1_in_d2_r  <= s1_in_d1_r;
        s1_in_d1_r  <= x_r;
        s1_out_d2_r <= s1_out_d1_r;
        s1_out_d1_r <= sec_y;
      end else begin
        s2_in_d2_r  <= s2_in_d1_r;
        s2_in_d1_r  <= x_r;
        s2_out_d2_r <= s2_out_d1_r;
        s2_out_d1_r <= sec_y;
      end
    end
  end

  // output: floor to integer, restore offset, clamp
  logic signed [INT_BITS-1:0]  y_int;
  logic signed [OUTV_BITS-1:0] y_off;
  logic [SAMPLE_BITS-1:0]      dac_nxt;
  logic                        clip_nxt;

  assign y_int = x_r[HIST_BITS-1:HIST_FRAC_BITS];
  assign y_off = {y_int[INT_BITS-1], y_int} + $signed(OUTV_BITS'(MIDSCALE));

  always_comb begin
    priority if (y_off[OUTV_BITS-1]) begin
      dac_nxt  = '0;
      clip_nxt = 1'b1;
    end else if (|y_off[OUTV_BITS-2:SAMPLE_BITS]) begin
      dac_nxt  = '1;
      clip_nxt = 1'b1;
    end else begin
      dac_nxt  = y_off[SAMPLE_BITS-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dac_r  <= dac_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.dac_sample = dac_r;
  assign out_if.clipped    = clip_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the two-section biquad filter: random and directed samples,
// coefficient bank loads and readback over APB, with a predictor of its own.
// Depends on cbq_pkg and the cbq_in_if / cbq_out_if channel interfaces.
module tb_top;
  import cbq_pkg::*;

  localparam int LONG_HOLD = 150;
  localparam int PHASES = 8;
  localparam int PHASE_SAMPLES = 82;

  localparam coef_t COEF_MAX = coef_t'((1 << (COEF_BITS - 1)) - 1);
  localparam coef_t COEF_MIN = coef_t'(1 << (COEF_BITS - 1));
  localparam coef_t COEF_UNITY = coef_t'(1 << COEF_FRAC_BITS);

  typedef enum {BANK_STABLE, BANK_WILD, BANK_EDGE} bank_kind_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] dac_sample;
    logic                   clipped;
  } dac_beat_t;

  class cascade_checker;
    localparam longint HIST_MAX = (longint'(1) <<< (HIST_BITS - 1)) - 1;
    localparam longint HIST_MIN = -(longint'(1) <<< (HIST_BITS - 1));

    logic [FF_BITS-1:0] ff_bank[2];
    logic [FB_BITS-1:0] fb_bank[2];
    hist_t x_d1[2], x_d2[2], y_d1[2], y_d2[2];
    dac_beat_t expected_dac[$];
    int n_samples, n_results, n_clipped, n_sat_sections, n_bank_writes, n_mismatch;

    function new();
      for (int s = 0; s < 2; s++) begin
        ff_bank[s] = FF_RESET;
        fb_bank[s] = '0;
        x_d1[s] = '0;
        x_d2[s] = '0;
        y_d1[s] = '0;
        y_d2[s] = '0;
      end
    endfunction

    function void flag(string what, logic [CFG_DATA_BITS-1:0] want,
                       logic [CFG_DATA_BITS-1:0] got);
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch in %s: expected %h, got %h", what, want, got);
    endfunction

    function coef_t tap(logic [FF_BITS-1:0] word, int k);
      return coef_t'(word >> (k * COEF_BITS));
    endfunction

    function hist_t run_section(int s, hist_t x);
      longint acc;
      acc = longint'(tap(ff_bank[s], 0)) * longint'(x)
          + longint'(tap(ff_bank[s], 1)) * longint'(x_d1[s])
          + longint'(tap(ff_bank[s], 2)) * longint'(x_d2[s])
          - longint'(tap(fb_bank[s], 0)) * longint'(y_d1[s])
          - longint'(tap(fb_bank[s], 1)) * longint'(y_d2[s]);
      acc = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (acc > HIST_MAX) begin
        acc = HIST_MAX;
        n_sat_sections++;
      end else if (acc < HIST_MIN) begin
        acc = HIST_MIN;
        n_sat_sections++;
      end
      x_d2[s] = x_d1[s];
      x_d1[s] = x;
      y_d2[s] = y_d1[s];
      y_d1[s] = hist_t'(acc);
      return hist_t'(acc);
    endfunction

    function void take_sample(logic [SAMPLE_BITS-1:0] adc);
      hist_t x, y1, y2;
      longint v;
      dac_beat_t e;
      n_samples++;
      x = hist_t'((longint'(adc) - longint'(MIDSCALE)) <<< HIST_FRAC_BITS);
      y1 = run_section(0, x);
      y2 = run_section(1, y1);
      v = (longint'(y2) >>> HIST_FRAC_BITS) + longint'(MIDSCALE);
      e.clipped = (v < 0) || (v > 65535);
      if (v < 0) v = 0;
      else if (v > 65535) v = 65535;
      e.dac_sample = SAMPLE_BITS'(v);
      expected_dac.push_back(e);
    endfunction

    function void check_result(logic [SAMPLE_BITS-1:0] dac, logic clip);
      dac_beat_t e;
      n_results++;
      if (clip) n_clipped++;
      if (expected_dac.size() == 0) begin
        flag("unexpected result beat", '0, dac);
        return;
      end
      e = expected_dac.pop_front();
      if (dac !== e.dac_sample) flag("dac_sample", e.dac_sample, dac);
      if (clip !== e.clipped) flag("clipped", e.clipped, clip);
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      n_bank_writes++;
      case (idx)
        REG_SEC1_FF: ff_bank[0] = val[FF_BITS-1:0];
        REG_SEC1_FB: fb_bank[0] = val[FB_BITS-1:0];
        REG_SEC2_FF: ff_bank[1] = val[FF_BITS-1:0];
        REG_SEC2_FB: fb_bank[1] = val[FB_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [CFG_DATA_BITS-1:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_SEC1_FF: return CFG_DATA_BITS'(ff_bank[0]);
        REG_SEC1_FB: return CFG_DATA_BITS'(fb_bank[0]);
        REG_SEC2_FF: return CFG_DATA_BITS'(ff_bank[1]);
        REG_SEC2_FB: return CFG_DATA_BITS'(fb_bank[1]);
        default: return '0;
      endcase
    endfunction

    function void check_readback(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] got);
      if (got !== reg_value(idx)) flag($sformatf("register %0d readback", idx),
                                       reg_value(idx), got);
    endfunction

    function int pending();
      return expected_dac.size();
    endfunction

    function int failures();
      return n_mismatch + expected_dac.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata, prdata;
  logic pready;
  bit in_quiet, out_quiet, long_hold;

  cbq_in_if in_ch ();
  cbq_out_if out_ch ();

  cascade_checker sb = new();

  cascaded_biquad_iir_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.take_sample(in_ch.adc_sample);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.dac_sample, out_ch.clipped);
  end

  // result side: random gaps per beat, one long hold on request
  initial begin : dac_sink
    int gap;
    bit holding;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      holding = long_hold;
      gap = holding ? LONG_HOLD : (out_quiet ? 0 : $urandom_range(0, 3));
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        if (holding) long_hold = 1'b0;
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.adc_sample <= s;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  // drop valid and hold until every filtered sample is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic [1:0] idx, input bit wr,
                            input logic [CFG_DATA_BITS-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CFG_ADDR_BITS'(idx) << CFG_IDX_LSB;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) sb.set_reg(idx, val);
    else sb.check_readback(idx, prdata);
    @(negedge clk);
  endtask

  task automatic load_bank(input logic [CFG_DATA_BITS-1:0] ff1, fb1, ff2, fb2);
    apb_access(REG_SEC1_FF, 1'b1, ff1);
    apb_access(REG_SEC1_FF, 1'b0, '0);
    apb_access(REG_SEC1_FB, 1'b1, fb1);
    apb_access(REG_SEC1_FB, 1'b0, '0);
    apb_access(REG_SEC2_FF, 1'b1, ff2);
    apb_access(REG_SEC2_FF, 1'b0, '0);
    apb_access(REG_SEC2_FB, 1'b1, fb2);
    apb_access(REG_SEC2_FB, 1'b0, '0);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pack_ff(coef_t b0, coef_t b1, coef_t b2);
    return CFG_DATA_BITS'({b2, b1, b0});
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pack_fb(coef_t a1, coef_t a2);
    return CFG_DATA_BITS'({a2, a1});
  endfunction

  function automatic coef_t pick_coef(bank_kind_t kind, int span);
    if (kind == BANK_EDGE) begin
      case ($urandom_range(0, 4))
        0: return COEF_MAX;
        1: return COEF_MIN;
        2: return COEF_UNITY;
        3: return coef_t'(-1);
        default: return '0;
      endcase
    end
    return coef_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // junk above the fields must be dropped by the block
  function automatic logic [CFG_DATA_BITS-1:0] ff_word(bank_kind_t kind);
    logic [CFG_DATA_BITS-1:0] w;
    w = {$urandom, $urandom};
    if (kind != BANK_WILD)
      w[FF_BITS-1:0] = {pick_coef(kind, 32768), pick_coef(kind, 32768),
                        pick_coef(kind, 32768)};
    return w;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] fb_word(bank_kind_t kind);
    logic [CFG_DATA_BITS-1:0] w;
    w = {$urandom, $urandom};
    if (kind != BANK_WILD)
      w[FB_BITS-1:0] = {pick_coef(kind, 19660), pick_coef(kind, 39321)};
    return w;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? '1 : '0;
      1, 2: return MIDSCALE + SAMPLE_BITS'($urandom_range(0, 512)) - SAMPLE_BITS'(256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [SAMPLE_BITS-1:0] edge_samples[10];
    bank_kind_t kind;
    edge_samples = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFE,
                     16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h8001};
    in_ch.valid = 1'b0;
    in_ch.adc_sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    long_hold = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apb_access(REG_SEC1_FF, 1'b0, '0);
    apb_access(REG_SEC1_FB, 1'b0, '0);
    apb_access(REG_SEC2_FF, 1'b0, '0);
    apb_access(REG_SEC2_FB, 1'b0, '0);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);

    // reset bank is a straight pass-through
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    drain_results();

    // gain just above one lands the output between -0x8000 and -0x7FFF
    load_bank(pack_ff(COEF_UNITY + coef_t'(1), '0, '0), '0,
              pack_ff(COEF_UNITY, '0, '0), '0);
    send_sample(16'h0000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    drain_results();

    // section overflow with full-scale coefficients
    load_bank(pack_ff(COEF_MAX, COEF_MAX, COEF_MAX), pack_fb(COEF_MIN, COEF_MAX),
              pack_ff(COEF_MAX, COEF_MAX, COEF_MAX), pack_fb(COEF_MIN, COEF_MAX));
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(MIDSCALE);
    send_sample(16'h0000);
    drain_results();

    load_bank(pack_ff(COEF_MIN, COEF_MIN, COEF_MIN), '0,
              pack_ff(COEF_MAX, '0, '0), pack_fb(coef_t'(-1), '0));
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(MIDSCALE);
    drain_results();

    load_bank('1, '1, '1, '1);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      kind = (p % 4 == 1) ? BANK_WILD : (p % 4 == 3) ? BANK_EDGE : BANK_STABLE;
      in_quiet = (p == 0);
      out_quiet = (p == 0);
      load_bank(ff_word(kind), fb_word(kind), ff_word(kind), fb_word(kind));
      long_hold = (p == 2);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (p == 4 && i == PHASE_SAMPLES / 2) drain_results();
        send_sample(pick_sample());
      end
      drain_results();
    end

    repeat (20) @(negedge clk);
    $display("Ran %0d samples over %0d coefficient writes: %0d results, %0d clipped,",
             sb.n_samples, sb.n_bank_writes, sb.n_results, sb.n_clipped);
    $display("%0d saturated section outputs, %0d mismatches.",
             sb.n_sat_sections, sb.n_mismatch);
    if (sb.failures() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
